>>> hw/rtl/rrsp_pkg.sv
package rrsp_pkg;

    localparam int SENSORS  = 4;
    localparam int ADDR_W   = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam int SENSOR_W = 3;
    localparam int FID_W    = 29;

    localparam logic [SENSOR_W-1:0] SENSOR_FIRST = SENSOR_W'(1);
    localparam logic [SENSOR_W-1:0] SENSOR_LAST  = SENSOR_W'(SENSORS);

    localparam logic [FID_W-1:0] ID_BASE  = FID_W'(32'h200);
    localparam logic [FID_W-1:0] ID_FIRST = FID_W'(32'h201);
    localparam logic [FID_W-1:0] ID_LAST  = FID_W'(32'h200 + SENSORS);

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 144;

    // command codes on s_tuser
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_FRAME = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_POLL_INTERVAL  = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_LIMIT  = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_CODE   = 2'd2;
    localparam logic [1:0] REG_NO_TARGET_CODE = 2'd3;

    // operations carried into the record stage
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_FRAME = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [15:0] POLL_INTERVAL_RESET  = 16'd8;
    localparam logic [7:0]  TIMEOUT_LIMIT_RESET  = 8'd10;
    localparam logic [7:0]  TIMEOUT_CODE_RESET   = 8'hff;
    localparam logic [7:0]  NO_TARGET_CODE_RESET = 8'h00;
    localparam logic [15:0] COUNTDOWN_RESET      = 16'd8;
    localparam logic [7:0]  MISS_MAX             = 8'hff;

    typedef struct packed {
        logic [23:0] distance;
        logic [7:0]  status;
        logic [15:0] strength;
        logic [15:0] reserved_word;
        logic [7:0]  miss_count;
        logic [31:0] recv_count;
        logic        seen;
    } rec_t;

    localparam rec_t REC_RESET = '{
        distance:      24'd0,
        status:        NO_TARGET_CODE_RESET,
        strength:      16'd0,
        reserved_word: 16'd0,
        miss_count:    8'd0,
        recv_count:    32'd0,
        seen:          1'b0
    };

    localparam logic [31:0] SEND_RESET = 32'd0;

    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              we_a;
        logic [ADDR_W-1:0] wr_addr_a;
        rec_t              wr_data_a;
        logic              we_b;
        logic [ADDR_W-1:0] wr_addr_b;
        logic [31:0]       wr_data_b;
    } store_req_t;

endpackage

>>> hw/rtl/round_robin_sensor_poller.sv
// Polling master for SENSORS CAN distance sensors. Input words carry a
// command in s_tuser (tick, received frame, record read); one word is
// taken per clock unless a held output stalls the record stage; each
// yields at most one output word, via the record stage and the output
// register. Per-sensor records sit in two single-port-write RAMs (record
// fields, send count) read at acceptance, ahead of a read-modify-write
// stage with a same-edge bypass, so words for the same sensor may follow
// back to back. Frames with identifiers outside 0x201..0x200+SENSORS,
// out-of-range reads and command 3 are consumed silently. Writes to
// no_target_code are accepted but records take that status only at reset.
module round_robin_sensor_poller
    import rrsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // fields, low to high: frame_id[28:0], frame_payload[92:29],
    // tx_ready[93], read_sensor[96:94], zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]           s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // sensor[2:0], poll_sent[3], distance[27:4], status[35:28],
    // strength[51:36], reserved_word[67:52], miss_count[75:68],
    // recv_count[107:76], send_count[139:108], zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // kind[0]
    output logic                 m_tuser,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    logic [15:0] poll_interval_reg;
    logic [7:0]  timeout_limit_reg;
    logic [7:0]  timeout_code_reg;

    logic [15:0]         countdown_reg;
    logic [15:0]         countdown_next;
    logic [SENSOR_W-1:0] cur_sensor_reg;
    logic [SENSOR_W-1:0] cur_sensor_next;

    logic                s1_valid_reg;
    logic [1:0]          s1_op_reg;
    logic [SENSOR_W-1:0] s1_sensor_reg;
    logic                s1_txr_reg;
    logic [63:0]         s1_payload_reg;
    logic [ADDR_W-1:0]   s1_addr_a_reg;
    logic [ADDR_W-1:0]   s1_addr_b_reg;

    logic                m_valid_reg;
    logic                m_kind_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic [1:0]          in_cmd;
    logic [FID_W-1:0]    in_fid;
    logic [63:0]         in_payload;
    logic                in_txr;
    logic [SENSOR_W-1:0] in_rs;

    logic                accept;
    logic                op_ok;
    logic [1:0]          op;
    logic [SENSOR_W-1:0] op_sensor;
    logic [ADDR_W-1:0]   op_addr_a;
    logic [ADDR_W-1:0]   op_addr_b;
    logic [SENSOR_W-1:0] next_sensor;

    store_req_t          req;
    rec_t                rd_a;
    logic [31:0]         rd_b;
    rec_t                upd;
    logic                has_result;
    logic                adv;
    logic                fire;
    logic [M_TDATA_W-1:0] res_data;

    assign in_cmd     = s_tuser;
    assign in_fid     = s_tdata[28:0];
    assign in_payload = s_tdata[92:29];
    assign in_txr     = s_tdata[93];
    assign in_rs      = s_tdata[96:94];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_interval_reg <= POLL_INTERVAL_RESET;
            timeout_limit_reg <= TIMEOUT_LIMIT_RESET;
            timeout_code_reg  <= TIMEOUT_CODE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_POLL_INTERVAL:  poll_interval_reg <= cfg_data;
                REG_TIMEOUT_LIMIT:  timeout_limit_reg <= cfg_data[7:0];
                REG_TIMEOUT_CODE:   timeout_code_reg  <= cfg_data[7:0];
                REG_NO_TARGET_CODE: ;
                default: ;
            endcase
        end
    end

    // decode at acceptance
    always_comb
    begin
        next_sensor = (cur_sensor_reg == SENSOR_LAST) ? SENSOR_FIRST
                                                       : cur_sensor_reg + SENSOR_W'(1);
        op_ok           = 1'b0;
        op              = OP_TICK;
        op_sensor       = next_sensor;
        op_addr_a       = ADDR_W'(cur_sensor_reg - SENSOR_FIRST);
        op_addr_b       = ADDR_W'(next_sensor - SENSOR_FIRST);
        countdown_next  = countdown_reg;
        cur_sensor_next = cur_sensor_reg;
        case (in_cmd)
            CMD_TICK:
            begin
                if (countdown_reg == 16'd0)
                begin
                    op_ok           = 1'b1;
                    countdown_next  = poll_interval_reg;
                    cur_sensor_next = next_sensor;
                end
                else
                begin
                    countdown_next = countdown_reg - 16'd1;
                end
            end
            CMD_FRAME:
            begin
                op        = OP_FRAME;
                op_ok     = (in_fid >= ID_FIRST) && (in_fid <= ID_LAST);
                op_addr_a = ADDR_W'(in_fid - ID_FIRST);
            end
            CMD_READ:
            begin
                op        = OP_READ;
                op_ok     = (in_rs >= SENSOR_FIRST) && (in_rs <= SENSOR_LAST);
                op_sensor = in_rs;
                op_addr_a = ADDR_W'(in_rs - SENSOR_FIRST);
                op_addr_b = ADDR_W'(in_rs - SENSOR_FIRST);
            end
            default: ;
        endcase
    end

    // record stage
    always_comb
    begin
        upd        = rd_a;
        has_result = 1'b0;
        res_data   = '0;
        case (s1_op_reg)
            OP_TICK:
            begin
                has_result = 1'b1;
                if (rd_a.seen)
                begin
                    upd.miss_count = 8'd0;
                    upd.seen       = 1'b0;
                end
                else if (rd_a.miss_count > timeout_limit_reg)
                begin
                    upd.status = timeout_code_reg;
                end
                else if (rd_a.miss_count < MISS_MAX)
                begin
                    upd.miss_count = rd_a.miss_count + 8'd1;
                end
                res_data[2:0] = s1_sensor_reg;
                res_data[3]   = s1_txr_reg;
            end
            OP_FRAME:
            begin
                upd.distance      = s1_payload_reg[23:0];
                upd.status        = s1_payload_reg[31:24];
                upd.strength      = s1_payload_reg[47:32];
                upd.reserved_word = s1_payload_reg[63:48];
                upd.seen          = 1'b1;
                upd.recv_count    = rd_a.recv_count + 32'd1;
            end
            OP_READ:
            begin
                has_result        = 1'b1;
                res_data[2:0]     = s1_sensor_reg;
                res_data[27:4]    = rd_a.distance;
                res_data[35:28]   = rd_a.status;
                res_data[51:36]   = rd_a.strength;
                res_data[67:52]   = rd_a.reserved_word;
                res_data[75:68]   = rd_a.miss_count;
                res_data[107:76]  = rd_a.recv_count;
                res_data[139:108] = rd_b;
            end
            default: ;
        endcase
    end

    assign adv      = !has_result || !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || adv;
    assign accept   = s_tvalid && s_tready;
    assign fire     = s1_valid_reg && adv;

    always_comb
    begin
        req.rd_addr_a = accept ? op_addr_a : s1_addr_a_reg;
        req.rd_addr_b = accept ? op_addr_b : s1_addr_b_reg;
        req.we_a      = fire && ((s1_op_reg == OP_TICK) || (s1_op_reg == OP_FRAME));
        req.wr_addr_a = s1_addr_a_reg;
        req.wr_data_a = upd;
        req.we_b      = fire && (s1_op_reg == OP_TICK) && s1_txr_reg;
        req.wr_addr_b = s1_addr_b_reg;
        req.wr_data_b = rd_b + 32'd1;
    end

    rrsp_store u_store (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            countdown_reg  <= COUNTDOWN_RESET;
            cur_sensor_reg <= SENSOR_FIRST;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                countdown_reg  <= countdown_next;
                cur_sensor_reg <= cur_sensor_next;
                s1_valid_reg   <= op_ok;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (fire && has_result)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg      <= op;
            s1_sensor_reg  <= op_sensor;
            s1_txr_reg     <= in_txr;
            s1_payload_reg <= in_payload;
            s1_addr_a_reg  <= op_addr_a;
            s1_addr_b_reg  <= op_addr_b;
        end
        if (fire && has_result)
        begin
            m_data_reg <= res_data;
            m_kind_reg <= (s1_op_reg == OP_READ);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;

endmodule

>>> hw/rtl/rrsp_ram.sv
module rrsp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/rrsp_store.sv
module rrsp_store
    import rrsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_req_t req,
    output rec_t       rd_a,
    output logic [31:0] rd_b
);

    localparam int REC_W = $bits(rec_t);

    logic [REC_W-1:0]  ram_a_rd;
    logic [31:0]       ram_b_rd;
    logic [SENSORS-1:0] valid_a_reg;
    logic [SENSORS-1:0] valid_b_reg;
    logic              vld_a_reg;
    logic              vld_b_reg;
    logic              hit_a_reg;
    logic              hit_b_reg;
    rec_t              fwd_a_reg;
    logic [31:0]       fwd_b_reg;

    rrsp_ram #(
        .WIDTH (REC_W),
        .DEPTH (SENSORS),
        .ADDR_W(ADDR_W)
    ) u_ram_rec (
        .clk    (clk),
        .we     (req.we_a),
        .wr_addr(req.wr_addr_a),
        .wr_data(req.wr_data_a),
        .rd_addr(req.rd_addr_a),
        .rd_data(ram_a_rd)
    );

    rrsp_ram #(
        .WIDTH (32),
        .DEPTH (SENSORS),
        .ADDR_W(ADDR_W)
    ) u_ram_send (
        .clk    (clk),
        .we     (req.we_b),
        .wr_addr(req.wr_addr_b),
        .wr_data(req.wr_data_b),
        .rd_addr(req.rd_addr_b),
        .rd_data(ram_b_rd)
    );

    // entries never written read as their reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= '0;
            valid_b_reg <= '0;
            vld_a_reg   <= 1'b0;
            vld_b_reg   <= 1'b0;
            hit_a_reg   <= 1'b0;
            hit_b_reg   <= 1'b0;
        end
        else
        begin
            if (req.we_a)
            begin
                valid_a_reg[req.wr_addr_a] <= 1'b1;
            end
            if (req.we_b)
            begin
                valid_b_reg[req.wr_addr_b] <= 1'b1;
            end
            vld_a_reg <= valid_a_reg[req.rd_addr_a];
            vld_b_reg <= valid_b_reg[req.rd_addr_b];
            hit_a_reg <= req.we_a && (req.wr_addr_a == req.rd_addr_a);
            hit_b_reg <= req.we_b && (req.wr_addr_b == req.rd_addr_b);
        end
    end

    // write-to-read bypass for the same edge
    always_ff @(posedge clk)
    begin
        fwd_a_reg <= req.wr_data_a;
        fwd_b_reg <= req.wr_data_b;
    end

    always_comb
    begin
        if (hit_a_reg)
        begin
            rd_a = fwd_a_reg;
        end
        else if (vld_a_reg)
        begin
            rd_a = rec_t'(ram_a_rd);
        end
        else
        begin
            rd_a = REC_RESET;
        end

        if (hit_b_reg)
        begin
            rd_b = fwd_b_reg;
        end
        else if (vld_b_reg)
        begin
            rd_b = ram_b_rd;
        end
        else
        begin
            rd_b = SEND_RESET;
        end
    end

endmodule

>>> dv/round_robin_sensor_poller_tb.sv
`timescale 1ns / 1ps

module round_robin_sensor_poller_tb;
    import rrsp_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 150;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PRINT_CAP      = 30;

    localparam logic       KIND_POLL   = 1'b0;
    localparam logic       KIND_RECORD = 1'b1;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    // tdata order, low to high: frame_id, payload, tx_ready, read_sensor
    typedef struct packed {
        logic [2:0]  read_sensor;
        logic        tx_ready;
        logic [63:0] payload;
        logic [28:0] frame_id;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  sensor;
        logic        poll_sent;
        logic [23:0] distance;
        logic [7:0]  status;
        logic [15:0] strength;
        logic [15:0] reserved_word;
        logic [7:0]  miss_count;
        logic [31:0] recv_count;
        logic [31:0] send_count;
    } poll_rec_t;

    typedef struct packed {
        logic [1:0] cmd;
        in_word_t   w;
        logic       typed;
        poll_rec_t  rec;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [15:0]          cfg_data;

    // poller state as the testbench sees it
    logic [15:0] cd;
    logic [15:0] poll_interval;
    logic [7:0]  lim;
    logic [7:0]  tcode;
    logic [2:0]  cur;
    logic        seen [1:SENSORS];
    logic [23:0] dst_mm [1:SENSORS];
    logic [7:0]  stat [1:SENSORS];
    logic [15:0] strg [1:SENSORS];
    logic [15:0] resv [1:SENSORS];
    logic [7:0]  miss [1:SENSORS];
    logic [31:0] recv [1:SENSORS];
    logic [31:0] sent [1:SENSORS];

    poll_rec_t awaited_words [$];
    dir_row_t  dir_rows [$];

    int  errors        = 0;
    int  words_in      = 0;
    int  polls_out     = 0;
    int  records_out   = 0;
    int  timeouts_hit  = 0;
    int  miss_peak     = 0;
    int  src_idle_pct  = 0;
    int  snk_stall_pct = 0;
    bit  hold_burst    = 1'b0;

    round_robin_sensor_poller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_CAP)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic match_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    function automatic poll_rec_t known_rec(logic kind, logic [2:0] sensor, logic psent,
                                            logic [23:0] d, logic [7:0] st,
                                            logic [15:0] sg, logic [15:0] rw,
                                            logic [31:0] rc, logic [31:0] sc);
        known_rec = '{kind, sensor, psent, d, st, sg, rw, 8'd0, rc, sc};
    endfunction

    function automatic void add_row(logic [1:0] cmd, logic [28:0] fid, logic [63:0] pay,
                                    logic txr, logic [2:0] rs, logic typed,
                                    poll_rec_t rec);
        dir_row_t row;
        row.cmd           = cmd;
        row.w.frame_id    = fid;
        row.w.payload     = pay;
        row.w.tx_ready    = txr;
        row.w.read_sensor = rs;
        row.typed         = typed;
        row.rec           = rec;
        dir_rows.push_back(row);
    endfunction

    task automatic poller_step(input logic [1:0] cmd, input in_word_t w,
                               output bit emits, output poll_rec_t r);
        logic [2:0] s;
        emits = 1'b0;
        r     = '0;
        case (cmd)
            CMD_TICK: begin
                if (cd != 16'd0) begin
                    cd = cd - 16'd1;
                end else begin
                    s = cur;
                    if (seen[s]) begin
                        miss[s] = 8'd0;
                        seen[s] = 1'b0;
                    end else if (miss[s] > lim) begin
                        stat[s] = tcode;
                        timeouts_hit++;
                    end else if (miss[s] != MISS_MAX) begin
                        miss[s] = miss[s] + 8'd1;
                    end
                    if (int'(miss[s]) > miss_peak)
                        miss_peak = int'(miss[s]);
                    s   = (s == SENSOR_LAST) ? SENSOR_FIRST : s + 3'd1;
                    cur = s;
                    if (w.tx_ready)
                        sent[s] = sent[s] + 32'd1;
                    cd          = poll_interval;
                    r.kind      = KIND_POLL;
                    r.sensor    = s;
                    r.poll_sent = w.tx_ready;
                    emits       = 1'b1;
                end
            end
            CMD_FRAME: begin
                if (w.frame_id >= ID_FIRST && w.frame_id <= ID_LAST) begin
                    s         = 3'(w.frame_id - ID_BASE);
                    dst_mm[s] = w.payload[23:0];
                    stat[s]   = w.payload[31:24];
                    strg[s]   = w.payload[47:32];
                    resv[s]   = w.payload[63:48];
                    seen[s]   = 1'b1;
                    recv[s]   = recv[s] + 32'd1;
                end
            end
            CMD_READ: begin
                if (w.read_sensor >= SENSOR_FIRST && w.read_sensor <= SENSOR_LAST) begin
                    s     = w.read_sensor;
                    r     = '{KIND_RECORD, s, 1'b0, dst_mm[s], stat[s], strg[s], resv[s],
                              miss[s], recv[s], sent[s]};
                    emits = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic offer_word(input logic [1:0] cmd, input in_word_t w, input logic typed,
                              input poll_rec_t typed_rec);
        int        gap;
        bit        emits;
        poll_rec_t r;
        gap = 0;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'(w);
        do @(posedge clk); while (!s_tready);
        words_in++;
        poller_step(cmd, w, emits, r);
        if (typed)
        begin
            r     = typed_rec;
            emits = 1'b1;
        end
        if (emits)
            awaited_words.push_back(r);
    endtask

    task automatic await_all_out();
        s_tvalid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_registers(input logic [15:0] interval, input logic [7:0] lim_v,
                                 input logic [7:0] tcode_v, input logic [7:0] ntcode_v);
        logic [1:0]  idx [4];
        logic [15:0] val [4];
        idx = '{REG_POLL_INTERVAL, REG_TIMEOUT_LIMIT, REG_TIMEOUT_CODE, REG_NO_TARGET_CODE};
        // upper byte of the 8-bit registers is junk on purpose
        val = '{interval, {8'($urandom), lim_v}, {8'($urandom), tcode_v},
                {8'($urandom), ntcode_v}};
        await_all_out();
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            case (idx[i])
                REG_POLL_INTERVAL: poll_interval = val[i];
                REG_TIMEOUT_LIMIT: lim = val[i][7:0];
                REG_TIMEOUT_CODE:  tcode = val[i][7:0];
                default: ; // no-target code only lands in records at reset
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_word(input bit starve_first, output logic [1:0] cmd,
                             output in_word_t w);
        int roll;
        w.frame_id    = 29'($urandom);
        w.payload     = {$urandom, $urandom};
        w.tx_ready    = 1'($urandom);
        w.read_sensor = 3'($urandom_range(SENSORS, 1));
        roll          = $urandom_range(99);
        if (starve_first)
        begin
            // sensor 1 never answers, so its miss count climbs to the top
            if (roll < 92)
                cmd = CMD_TICK;
            else if (roll < 97)
                cmd = CMD_READ;
            else
            begin
                cmd        = CMD_FRAME;
                w.frame_id = ID_FIRST + 29'($urandom_range(SENSORS - 1, 1));
            end
        end
        else if (roll < 40)
            cmd = CMD_TICK;
        else if (roll < 70)
        begin
            cmd = CMD_FRAME;
            if ($urandom_range(3) != 0)
                w.frame_id = ID_FIRST + 29'($urandom_range(SENSORS - 1, 0));
            else if ($urandom_range(1) != 0)
                w.frame_id = ($urandom_range(1) != 0) ? ID_BASE : ID_LAST + 29'd1;
        end
        else if (roll < 95)
        begin
            cmd = CMD_READ;
            if ($urandom_range(6) == 0)
                w.read_sensor = 3'($urandom_range(7));
        end
        else
            cmd = CMD_UNUSED;
    endtask

    task automatic run_phase(input int n, input int idle, input int stall,
                             input bit starve_first, input bit hold_mid, input bit pause_mid);
        logic [1:0] cmd;
        in_word_t   w;
        src_idle_pct  = idle;
        snk_stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2 && hold_mid)
                hold_burst = 1'b1;
            if (i == n / 2 && pause_mid)
                await_all_out();
            pick_word(starve_first, cmd, w);
            offer_word(cmd, w, 1'b0, '0);
        end
    endtask

    // output side: random backpressure plus one long hold on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_burst)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_burst = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge clk)
    begin : out_check
        poll_rec_t got;
        poll_rec_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tuser, m_tdata[2:0], m_tdata[3], m_tdata[27:4], m_tdata[35:28],
                    m_tdata[51:36], m_tdata[67:52], m_tdata[75:68], m_tdata[107:76],
                    m_tdata[139:108]};
            if (awaited_words.size() == 0)
                report_mismatch("output word with nothing expected");
            else
            begin
                want = awaited_words.pop_front();
                if (want.kind == KIND_POLL)
                    polls_out++;
                else
                    records_out++;
                match_field("kind", 32'(got.kind), 32'(want.kind));
                match_field("sensor", 32'(got.sensor), 32'(want.sensor));
                match_field("poll_sent", 32'(got.poll_sent), 32'(want.poll_sent));
                match_field("distance", 32'(got.distance), 32'(want.distance));
                match_field("status", 32'(got.status), 32'(want.status));
                match_field("strength", 32'(got.strength), 32'(want.strength));
                match_field("reserved_word", 32'(got.reserved_word),
                            32'(want.reserved_word));
                match_field("miss_count", 32'(got.miss_count), 32'(want.miss_count));
                match_field("recv_count", got.recv_count, want.recv_count);
                match_field("send_count", got.send_count, want.send_count);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("round_robin_sensor_poller test failed");
        $finish;
    end

    initial
    begin : main_seq
        dir_row_t row;
        in_word_t w;
        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = CMD_TICK;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_POLL_INTERVAL;
        cfg_data  = '0;

        cd            = COUNTDOWN_RESET;
        cur           = SENSOR_FIRST;
        poll_interval = POLL_INTERVAL_RESET;
        lim           = TIMEOUT_LIMIT_RESET;
        tcode         = TIMEOUT_CODE_RESET;
        for (int s = 1; s <= SENSORS; s++)
        begin
            seen[s]   = 1'b0;
            dst_mm[s] = '0;
            stat[s]   = NO_TARGET_CODE_RESET;
            strg[s]   = '0;
            resv[s]   = '0;
            miss[s]   = '0;
            recv[s]   = '0;
            sent[s]   = '0;
        end

        // records straight out of reset, out-of-range reads, unused command
        add_row(CMD_READ, 0, 0, 0, 3'd1, 1,
                known_rec(KIND_RECORD, 3'd1, 0, 0, NO_TARGET_CODE_RESET, 0, 0, 0, 0));
        add_row(CMD_READ, 0, 0, 0, 3'd4, 1,
                known_rec(KIND_RECORD, 3'd4, 0, 0, NO_TARGET_CODE_RESET, 0, 0, 0, 0));
        add_row(CMD_READ, 0, 0, 0, 3'd0, 0, '0);
        add_row(CMD_READ, 0, 0, 0, 3'd7, 0, '0);
        add_row(CMD_UNUSED, '1, '1, 1, 3'd1, 0, '0);
        // frame parsing, little-endian fields
        add_row(CMD_FRAME, ID_FIRST, '1, 0, 3'd0, 0, '0);
        add_row(CMD_READ, 0, 0, 0, 3'd1, 1,
                known_rec(KIND_RECORD, 3'd1, 0, 24'hffffff, 8'hff, 16'hffff, 16'hffff,
                          32'd1, 32'd0));
        add_row(CMD_FRAME, ID_LAST, 64'h0123_4567_89ab_cdef, 0, 3'd0, 0, '0);
        add_row(CMD_READ, 0, 0, 0, 3'd4, 1,
                known_rec(KIND_RECORD, 3'd4, 0, 24'habcdef, 8'h89, 16'h4567, 16'h0123,
                          32'd1, 32'd0));
        // foreign identifiers
        add_row(CMD_FRAME, ID_BASE, '1, 0, 3'd0, 0, '0);
        add_row(CMD_FRAME, ID_LAST + 29'd1, '1, 0, 3'd0, 0, '0);
        add_row(CMD_FRAME, '1, '1, 0, 3'd0, 0, '0);
        add_row(CMD_FRAME, ID_FIRST | 29'h1000_0000, '1, 0, 3'd0, 0, '0);
        add_row(CMD_FRAME, ID_FIRST + 29'd2, '0, 0, 3'd0, 0, '0);
        add_row(CMD_READ, 0, 0, 0, 3'd3, 1,
                known_rec(KIND_RECORD, 3'd3, 0, 0, 0, 0, 0, 32'd1, 32'd0));
        // countdown from reset, then the first poll
        for (int i = 0; i < COUNTDOWN_RESET; i++)
            add_row(CMD_TICK, '1, '1, i[0], 3'd7, 0, '0);
        add_row(CMD_TICK, 0, 0, 1, 3'd0, 1,
                known_rec(KIND_POLL, 3'd2, 1, 0, 0, 0, 0, 0, 0));
        add_row(CMD_READ, 0, 0, 0, 3'd2, 1,
                known_rec(KIND_RECORD, 3'd2, 0, 0, NO_TARGET_CODE_RESET, 0, 0, 0, 32'd1));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            offer_word(row.cmd, row.w, row.typed, row.rec);
        end

        set_registers(16'd0, 8'd0, 8'($urandom), 8'd255);
        run_phase(100, 0, 0, 0, 1, 0);
        set_registers(16'd3, 8'd2, 8'd0, 8'h5a);
        run_phase(100, 80, 0, 0, 0, 0);
        set_registers(16'd1, 8'd1, 8'd255, 8'd0);
        run_phase(100, 0, 80, 0, 0, 0);
        set_registers(16'($urandom_range(6)), 8'($urandom_range(5)), 8'($urandom),
                      8'($urandom));
        run_phase(150, 35, 35, 0, 0, 1);
        set_registers(16'd0, 8'd254, 8'($urandom), 8'($urandom));
        run_phase(1200, 0, 0, 1, 0, 0);

        // longest interval: reach one reload, then a short mixed tail
        set_registers(16'hffff, 8'd254, 8'd0, 8'd255);
        w.frame_id    = '0;
        w.payload     = '0;
        w.tx_ready    = 1'b1;
        w.read_sensor = SENSOR_FIRST;
        while (cd != 16'd0)
            offer_word(CMD_TICK, w, 1'b0, '0);
        offer_word(CMD_TICK, w, 1'b0, '0);
        run_phase(30, 35, 35, 0, 0, 0);

        await_all_out();
        if (awaited_words.size() != 0)
            report_mismatch($sformatf("%0d words never came out", awaited_words.size()));

        $display("ran %0d input words; checked %0d poll and %0d record words, %0d timeouts",
                 words_in, polls_out, records_out, timeouts_hit);
        $display("idle mixes none, in 80%%, out 80%%, both 35%%; miss count peak %0d",
                 miss_peak);
        if (errors == 0)
            $display("round_robin_sensor_poller test passed");
        else
            $display("round_robin_sensor_poller test failed");
        $finish;
    end

endmodule
